[hdl/mfc_pkg.sv]
// Shared types and constants for the masked frame checker.
// No dependencies; imported by masked_frame_checker.
`default_nettype none

package mfc_pkg;

   // fixed frame header geometry
   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned COUNT_W      = 32;
   localparam int unsigned CFG_W        = 32;
   localparam int unsigned CSR_INDEX_W  = 1;

   localparam logic [3:0] VERSION_EXPECTED = 4'h1;
   localparam logic [CFG_W-1:0] MAX_FRAME_SIZE_RESET = 32'd65536;
   localparam logic [CFG_W-1:0] MAX_AGE_MS_RESET     = 32'd300000;   // five minutes

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE_MS     = 1'b1;

   // header byte positions
   localparam logic [3:0] HB_FIRST   = 4'd0;
   localparam logic [3:0] HB_CHECK   = 4'd1;
   localparam logic [3:0] HB_LAST    = 4'd15;

   typedef enum logic [2:0] {
      ST_PENDING  = 3'd0,
      ST_OK       = 3'd1,
      ST_SHORT    = 3'd2,
      ST_BAD_VER  = 3'd3,
      ST_TOO_BIG  = 3'd4,
      ST_STALE    = 3'd5,
      ST_MISMATCH = 3'd6,
      ST_CHECKSUM = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      KIND_FRAME_HDR = 2'd0,
      KIND_APP_HDR   = 2'd1,
      KIND_PAYLOAD   = 2'd2
   } kind_type;

endpackage

`default_nettype wire

[hdl/masked_frame_checker.sv]
// Masked frame checker top level: header parse, payload unmask, frame status.
// Depends on mfc_pkg.
`default_nettype none

// The block takes a frame one byte per beat on the req_ channel and returns one
// result beat per byte on the rsp_ channel. The first 16 bytes are a big-endian
// header (version/reserved, check byte, 16-bit application header length,
// 32-bit payload length, 64-bit timestamp); every later byte is XORed with the
// timestamp byte selected by its data index mod 8 and tagged as application
// header or payload in rsp_tuser. The beat marked req_tlast ends the frame:
// its result carries rsp_tlast and the frame status, and the frame state
// clears. Version, size and age are judged on the last header byte with the
// now_ms of that beat. Throughput is one byte per clock while rsp_tready keeps
// up: the whole per-byte update sits between the input register and the
// result register, so an accepted beat goes from the input register into the
// result register, where rsp_tvalid rises and the result can be taken. The
// input register lets one more beat in while a result waits on rsp_tready.
// csr_ writes take effect at once and are meant for idle periods.
module masked_frame_checker
   import mfc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [71:0]            req_tdata,  // [7:0] data_byte, [71:8] now_ms
   input  wire logic                   req_tlast,  // last_byte
   // response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [127:0]                rsp_tdata,  // [7:0] out_byte, [10:8] status,
                                                   // [26:11] app_header_length,
                                                   // [58:27] payload_bytes,
                                                   // [122:59] frame_timestamp, rest 0
   output logic [1:0]                  rsp_tuser,  // [1:0] byte_kind
   output logic                        rsp_tlast,  // frame_done
   // configuration writes
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   // configuration
   logic [CFG_W-1:0] max_frame_size_ff;
   logic [CFG_W-1:0] max_age_ms_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [63:0] in_now_ff;

   // frame state
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic [7:0]         first_ff,   first_in;
   logic [7:0]         check_ff,   check_in;
   logic [15:0]        ahl_ff,     ahl_in;
   logic [31:0]        pl_ff,      pl_in;
   logic [63:0]        ts_ff,      ts_in;
   logic [7:0]         sum_ff,     sum_in;
   status_type         err_ff,     err_in;

   // result register
   logic        rsp_valid_ff;
   logic [7:0]  out_byte_ff,  out_byte_in;
   kind_type    kind_ff,      kind_in;
   logic        done_ff;
   status_type  status_ff,    status_in;
   logic [15:0] out_ahl_ff;
   logic [31:0] out_pl_ff;
   logic [63:0] out_ts_ff;

   logic advance;

   // move the held beat into the result register when that slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_size_ff <= MAX_FRAME_SIZE_RESET;
         max_age_ms_ff     <= MAX_AGE_MS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_FRAME_SIZE: max_frame_size_ff <= csr_wdata;
            CSR_MAX_AGE_MS:     max_age_ms_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register: hold the beat until it can advance
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[7:0];
         in_now_ff  <= req_tdata[71:8];
         in_last_ff <= req_tlast;
      end
   end

   // per-byte update
   logic               in_header;
   logic [3:0]         hpos;
   logic [COUNT_W-1:0] data_idx;
   logic [2:0]         mask_sel;
   logic [7:0]         mask_byte;
   logic [COUNT_W-1:0] count_inc;
   logic [32:0]        need;
   logic [63:0]        age;
   logic               stale;
   status_type         hdr_err;

   always_comb begin
      in_header = (count_ff[COUNT_W-1:4] == '0);
      hpos      = count_ff[3:0];
      data_idx  = count_ff - COUNT_W'(HEADER_BYTES);
      // data index mod 8 picks the timestamp byte, most significant first
      mask_sel  = ~count_ff[2:0];
      mask_byte = ts_ff[{mask_sel, 3'b000} +: 8];
      count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;

      first_in = first_ff;
      check_in = check_ff;
      ahl_in   = ahl_ff;
      pl_in    = pl_ff;
      ts_in    = ts_ff;
      sum_in   = sum_ff;

      if (in_header) begin
         out_byte_in = in_byte_ff;
         kind_in     = KIND_FRAME_HDR;
         if (hpos == HB_FIRST) begin
            first_in = in_byte_ff;
         end else if (hpos == HB_CHECK) begin
            check_in = in_byte_ff;
         end else if (hpos < 4'd4) begin
            ahl_in = {ahl_ff[7:0], in_byte_ff};
         end else if (hpos < 4'd8) begin
            pl_in = {pl_ff[23:0], in_byte_ff};
         end else begin
            ts_in = {ts_ff[55:0], in_byte_ff};
         end
      end else begin
         out_byte_in = in_byte_ff ^ mask_byte;
         kind_in     = (data_idx < {16'd0, ahl_ff}) ? KIND_APP_HDR : KIND_PAYLOAD;
         sum_in      = sum_ff + out_byte_in;
      end

      need  = 33'(HEADER_BYTES) + {17'd0, ahl_in} + {1'b0, pl_in};
      age   = in_now_ff - ts_in;
      stale = (ts_in < in_now_ff) && (age > {32'd0, max_age_ms_ff});

      if ((first_in[3:0] != VERSION_EXPECTED) || (first_in[7:4] != 4'h0)) begin
         hdr_err = ST_BAD_VER;
      end else if (need > {1'b0, max_frame_size_ff}) begin
         hdr_err = ST_TOO_BIG;
      end else if (stale) begin
         hdr_err = ST_STALE;
      end else begin
         hdr_err = ST_PENDING;
      end

      // latch the header verdict on the last header byte
      err_in = (in_header && (hpos == HB_LAST)) ? hdr_err : err_ff;

      // frame status, first failing check wins
      if (!in_last_ff) begin
         status_in = ST_PENDING;
      end else if (count_inc < COUNT_W'(HEADER_BYTES)) begin
         status_in = ST_SHORT;
      end else if (err_in != ST_PENDING) begin
         status_in = err_in;
      end else if (need != {1'b0, count_inc}) begin
         status_in = ST_MISMATCH;
      end else if (8'(sum_in + check_in) != 8'd0) begin
         status_in = ST_CHECKSUM;
      end else begin
         status_in = ST_OK;
      end

      count_in = count_inc;
   end

   // frame state: advance per byte, clear at frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         check_ff <= '0;
         ahl_ff   <= '0;
         pl_ff    <= '0;
         ts_ff    <= '0;
         sum_ff   <= '0;
         err_ff   <= ST_PENDING;
      end else if (advance) begin
         if (in_last_ff) begin
            count_ff <= '0;
            first_ff <= '0;
            check_ff <= '0;
            ahl_ff   <= '0;
            pl_ff    <= '0;
            ts_ff    <= '0;
            sum_ff   <= '0;
            err_ff   <= ST_PENDING;
         end else begin
            count_ff <= count_in;
            first_ff <= first_in;
            check_ff <= check_in;
            ahl_ff   <= ahl_in;
            pl_ff    <= pl_in;
            ts_ff    <= ts_in;
            sum_ff   <= sum_in;
            err_ff   <= err_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= out_byte_in;
         kind_ff     <= kind_in;
         done_ff     <= in_last_ff;
         status_ff   <= status_in;
         out_ahl_ff  <= ahl_in;
         out_pl_ff   <= pl_in;
         out_ts_ff   <= ts_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, out_ts_ff, out_pl_ff, out_ahl_ff, status_ff, out_byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = done_ff;

   // a stalled result with a full input register must block new beats
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && in_valid_ff) |-> !req_tready)
      else $error("request accepted while both stages are full");

   // status is only given on the frame-ending beat
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |-> (status_ff == ST_PENDING))
      else $error("status given on a beat that does not end the frame");

   a_done_has_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (status_ff != ST_PENDING))
      else $error("frame end without a status");

   // frame state clears after the last byte moves out
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (count_ff == '0 && sum_ff == '0))
      else $error("frame state not cleared at frame end");

   // header bytes are never tagged as data and vice versa
   a_kind_header: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((kind_ff == KIND_FRAME_HDR) == $past(in_header)))
      else $error("byte kind disagrees with header position");

endmodule

`default_nettype wire
